[design/slot_table_first_free_match_read_assert.svh]
// assertion macros used by the stft_check checker
`ifndef SLOT_TABLE_FIRST_FREE_MATCH_READ_ASSERT_SVH
`define SLOT_TABLE_FIRST_FREE_MATCH_READ_ASSERT_SVH

// property checked on every rising clock edge, no reset gating
`define STFT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("stft check failed");

// implication gated by reset
`define STFT_CHECK(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stft check failed");

`endif

[design/stft_pkg.sv]
package stft_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int KEY_W = 31;
  localparam int SIG_W = 8;
  localparam int PAY_W = 32;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_WRITE     = 2'd0;
  localparam func_t FUNC_RD_WALLET = 2'd1;
  localparam func_t FUNC_RD_TXID   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_STORED = 2'd0;
  localparam status_t STATUS_FULL   = 2'd1;
  localparam status_t STATUS_FOUND  = 2'd2;
  localparam status_t STATUS_NONE   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] tx_id;
    logic [SIG_W-1:0] wallet_sig;
    logic [SIG_W-1:0] server_sig;
    logic [PAY_W-1:0] payload;
  } rec_t;

  // request moving down the row of slots
  typedef struct packed {
    logic             valid;
    func_t            func;
    logic [KEY_W-1:0] key;
    rec_t             rec;
    logic             done;
    rec_t             res;
  } token_t;

endpackage

[design/stft_req_if.sv]
interface stft_req_if;
  logic                         valid;
  logic                         ready;
  stft_pkg::func_t              func;
  logic [stft_pkg::KEY_W-1:0]   match_key;
  logic [stft_pkg::KEY_W-1:0]   in_tx_id;
  logic [stft_pkg::SIG_W-1:0]   in_wallet_sig;
  logic [stft_pkg::SIG_W-1:0]   in_server_sig;
  logic [stft_pkg::PAY_W-1:0]   in_payload;

  modport source (
    output valid, func, match_key, in_tx_id, in_wallet_sig, in_server_sig, in_payload,
    input  ready
  );
  modport sink (
    input  valid, func, match_key, in_tx_id, in_wallet_sig, in_server_sig, in_payload,
    output ready
  );
endinterface

[design/stft_rsp_if.sv]
interface stft_rsp_if;
  logic                         valid;
  logic                         ready;
  stft_pkg::status_t            status;
  logic [stft_pkg::KEY_W-1:0]   out_tx_id;
  logic [stft_pkg::SIG_W-1:0]   out_wallet_sig;
  logic [stft_pkg::SIG_W-1:0]   out_server_sig;
  logic [stft_pkg::PAY_W-1:0]   out_payload;

  modport source (
    output valid, status, out_tx_id, out_wallet_sig, out_server_sig, out_payload,
    input  ready
  );
  modport sink (
    input  valid, status, out_tx_id, out_wallet_sig, out_server_sig, out_payload,
    output ready
  );
endinterface

[design/stft_cell.sv]
module stft_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  stft_pkg::token_t tok_in,
  output stft_pkg::token_t tok_out
);

  logic             slot_valid;
  stft_pkg::rec_t   slot_rec;
  stft_pkg::token_t tok;
  stft_pkg::token_t tok_next;
  logic             key_hit;
  logic             hit_wr;
  logic             hit_rd;

  always_comb begin
    case (tok_in.func)
      stft_pkg::FUNC_RD_WALLET: begin
        key_hit = (tok_in.key ==
                   {{(stft_pkg::KEY_W - stft_pkg::SIG_W){1'b0}}, slot_rec.wallet_sig});
      end
      stft_pkg::FUNC_RD_TXID: begin
        key_hit = (tok_in.key == slot_rec.tx_id);
      end
      default: begin
        key_hit = 1'b0;
      end
    endcase
    hit_wr = tok_in.valid && !tok_in.done && (tok_in.func == stft_pkg::FUNC_WRITE) &&
             !slot_valid;
    hit_rd = tok_in.valid && !tok_in.done && slot_valid && key_hit;
    tok_next = tok_in;
    if (hit_wr) begin
      tok_next.done = 1'b1;
    end
    if (hit_rd) begin
      tok_next.done = 1'b1;
      tok_next.res  = slot_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      tok.valid  <= 1'b0;
    end else if (adv) begin
      tok <= tok_next;
      if (hit_wr) begin
        slot_valid <= 1'b1;
      end else if (hit_rd) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit_wr) begin
      slot_rec <= tok_in.rec;
    end
  end

  assign tok_out = tok;

endmodule

[design/slot_table_first_free_match_read.sv]
// path: the token register of each slot cell in turn, then the result register
// throughput: one request per cycle unless stalled, set by the row of slot cells
// one stage per slot; a stalled result freezes the whole row until it is taken
// reset: synchronous, clears the slot and stage valid bits and the result valid bit
module slot_table_first_free_match_read #(
  parameter int SLOTS = stft_pkg::SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  stft_req_if.sink   req,
  stft_rsp_if.source rsp
);

  stft_pkg::token_t   tok [0:SLOTS];
  logic               adv;
  logic               out_valid;
  stft_pkg::status_t  out_status;
  stft_pkg::rec_t     out_rec;
  stft_pkg::status_t  status_next;
  stft_pkg::token_t   last;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  always_comb begin
    tok[0]                = '0;
    tok[0].valid          = req.valid;
    tok[0].func           = req.func;
    tok[0].key            = req.match_key;
    tok[0].rec.tx_id      = req.in_tx_id;
    tok[0].rec.wallet_sig = req.in_wallet_sig;
    tok[0].rec.server_sig = req.in_server_sig;
    tok[0].rec.payload    = req.in_payload;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    stft_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign last = tok[SLOTS];

  always_comb begin
    if (last.func == stft_pkg::FUNC_WRITE) begin
      status_next = last.done ? stft_pkg::STATUS_STORED : stft_pkg::STATUS_FULL;
    end else begin
      status_next = last.done ? stft_pkg::STATUS_FOUND : stft_pkg::STATUS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= status_next;
      out_rec    <= last.res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.out_tx_id      = out_rec.tx_id;
  assign rsp.out_wallet_sig = out_rec.wallet_sig;
  assign rsp.out_server_sig = out_rec.server_sig;
  assign rsp.out_payload    = out_rec.payload;

endmodule

[design/stft_check.sv]
`include "slot_table_first_free_match_read_assert.svh"

module stft_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input stft_pkg::status_t          rsp_status,
  input logic [stft_pkg::KEY_W-1:0] rsp_tx_id,
  input logic [stft_pkg::SIG_W-1:0] rsp_wallet_sig,
  input logic [stft_pkg::SIG_W-1:0] rsp_server_sig,
  input logic [stft_pkg::PAY_W-1:0] rsp_payload
);

  `STFT_ASSERT(a_rst_clears_out, rst |=> !rsp_valid)

  `STFT_CHECK(a_ready_when_empty, !rsp_valid, req_ready)

  `STFT_CHECK(a_zero_unless_found,
              rsp_valid && (rsp_status != stft_pkg::STATUS_FOUND),
              {rsp_tx_id, rsp_wallet_sig, rsp_server_sig, rsp_payload} == '0)

  `STFT_ASSERT(a_stall_holds, disable iff (rst) rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))

endmodule

bind slot_table_first_free_match_read stft_check u_stft_check (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_tx_id      (rsp.out_tx_id),
  .rsp_wallet_sig (rsp.out_wallet_sig),
  .rsp_server_sig (rsp.out_server_sig),
  .rsp_payload    (rsp.out_payload)
);

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stft_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int RANDOM_ITEMS = 1050;
  localparam longint CYCLE_LIMIT = 400000;
  localparam func_t FUNC_UNUSED = 2'd3;

  typedef struct packed {
    func_t            func;
    logic [KEY_W-1:0] key;
    rec_t             rec;
    logic             hold;
  } request_t;

  typedef struct packed {
    status_t status;
    rec_t    rec;
  } reply_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stft_req_if req_bus();
  stft_rsp_if rsp_bus();

  slot_table_first_free_match_read #(.SLOTS(SLOTS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  request_t request_q[$];
  reply_t   reply_q[$];

  // shadow copy of the slot table
  logic     slot_busy[SLOTS] = '{default: 1'b0};
  rec_t     slot_rec[SLOTS] = '{default: '0};

  int       items_taken = 0;
  int       results_seen = 0;
  int       total_items = 0;
  int       error_count = 0;
  longint   cycle_count = 0;
  int       status_tally[4] = '{default: 0};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic reply_t serve_request(request_t r);
    reply_t rep;
    bit     done;
    rep.status = STATUS_NONE;
    rep.rec = '0;
    done = 1'b0;
    if (r.func == FUNC_WRITE) begin
      rep.status = STATUS_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && !slot_busy[i]) begin
          slot_busy[i] = 1'b1;
          slot_rec[i] = r.rec;
          rep.status = STATUS_STORED;
          done = 1'b1;
        end
      end
    end else if (r.func == FUNC_RD_WALLET || r.func == FUNC_RD_TXID) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && slot_busy[i] &&
            ((r.func == FUNC_RD_WALLET) ? (KEY_W'(slot_rec[i].wallet_sig) == r.key)
                                        : (slot_rec[i].tx_id == r.key))) begin
          slot_busy[i] = 1'b0;
          rep.status = STATUS_FOUND;
          rep.rec = slot_rec[i];
          done = 1'b1;
        end
      end
    end
    return rep;
  endfunction

  function automatic request_t build_request(func_t f, logic [KEY_W-1:0] key,
                                             logic [KEY_W-1:0] tx, logic [SIG_W-1:0] ws,
                                             logic [SIG_W-1:0] ss, logic [PAY_W-1:0] pl,
                                             logic hold);
    request_t r;
    r.func = f;
    r.key = key;
    r.rec.tx_id = tx;
    r.rec.wallet_sig = ws;
    r.rec.server_sig = ss;
    r.rec.payload = pl;
    r.hold = hold;
    return r;
  endfunction

  function automatic rec_t random_rec();
    rec_t rr;
    rr.tx_id = KEY_W'($urandom);
    rr.wallet_sig = SIG_W'($urandom);
    rr.server_sig = SIG_W'($urandom);
    rr.payload = PAY_W'($urandom);
    return rr;
  endfunction

  function automatic void log_failure(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void compare_field(string field, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      log_failure($sformatf("result %0d: %s expected 0x%0h got 0x%0h",
                            results_seen, field, want, got));
    end
  endfunction

  initial begin : stimulus
    rec_t             rr;
    rec_t             recent_recs[$];
    logic [KEY_W-1:0] key;
    func_t            f;
    int               phase_left;
    int               write_pct;
    int               pick;

    // reads on an empty table and the unused selector
    rr = random_rec();
    request_q.push_back(build_request(FUNC_RD_WALLET, '0, rr.tx_id, rr.wallet_sig,
                                      rr.server_sig, rr.payload, 1'b0));
    request_q.push_back(build_request(FUNC_RD_TXID, '0, '1, '1, '1, '1, 1'b0));
    request_q.push_back(build_request(FUNC_UNUSED, '1, '1, '1, '1, '1, 1'b0));
    // fill every slot, with field extremes and duplicate keys
    for (int i = 0; i < SLOTS; i++) begin
      rr = random_rec();
      if (i == 0) rr = '0;
      if (i == 1) rr = '1;
      if (i % 4 == 2) rr.wallet_sig = 8'h5a;
      if (i == 3 || i == 7) rr.tx_id = 31'h1234;
      request_q.push_back(build_request(FUNC_WRITE, KEY_W'($urandom), rr.tx_id,
                                        rr.wallet_sig, rr.server_sig, rr.payload, 1'b0));
    end
    // write to a full table, after the pipe has drained
    rr = random_rec();
    request_q.push_back(build_request(FUNC_WRITE, '0, rr.tx_id, rr.wallet_sig,
                                      rr.server_sig, rr.payload, 1'b1));
    // wallet key above the signature range never matches
    request_q.push_back(build_request(FUNC_RD_WALLET, 31'h100, '0, '0, '0, '0, 1'b0));
    request_q.push_back(build_request(FUNC_RD_WALLET, 31'h5a, '0, '0, '0, '0, 1'b0));
    request_q.push_back(build_request(FUNC_RD_TXID, 31'h1234, '0, '0, '0, '0, 1'b0));
    rr = random_rec();
    request_q.push_back(build_request(FUNC_WRITE, '0, rr.tx_id, rr.wallet_sig,
                                      rr.server_sig, rr.payload, 1'b0));
    request_q.push_back(build_request(FUNC_RD_TXID, '1, '0, '0, '0, '0, 1'b0));

    phase_left = 0;
    write_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: write_pct = 25;
          1: write_pct = 50;
          2: write_pct = 75;
          default: write_pct = 90;
        endcase
      end
      phase_left--;
      rr = random_rec();
      key = KEY_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        f = FUNC_UNUSED;
      end else if (pick < 3 + write_pct * 97 / 100) begin
        f = FUNC_WRITE;
        if ($urandom_range(0, 3) == 0) rr.wallet_sig = SIG_W'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) rr.tx_id = KEY_W'($urandom_range(0, 3));
        recent_recs.push_back(rr);
        if (recent_recs.size() > 24) void'(recent_recs.pop_front());
      end else begin
        f = ($urandom_range(0, 1) == 0) ? FUNC_RD_WALLET : FUNC_RD_TXID;
        if (recent_recs.size() > 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, recent_recs.size() - 1);
          key = (f == FUNC_RD_WALLET) ? KEY_W'(recent_recs[pick].wallet_sig)
                                      : recent_recs[pick].tx_id;
        end else if (f == FUNC_RD_WALLET && $urandom_range(0, 1) == 0) begin
          key = KEY_W'($urandom_range(0, 255));
        end
      end
      request_q.push_back(build_request(f, key, rr.tx_id, rr.wallet_sig, rr.server_sig,
                                        rr.payload, $urandom_range(0, 149) == 0));
    end
    total_items = request_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_items) @(posedge clk);
    while (results_seen != total_items) @(posedge clk);
    repeat (2 * SLOTS + 20) @(posedge clk);
    if (reply_q.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", reply_q.size()));
    end

    $display("run covered %0d requests and %0d checked results in %0d cycles",
             items_taken, results_seen, cycle_count);
    $display("outcomes: %0d stored, %0d dropped on full table, %0d read hits, %0d misses",
             status_tally[STATUS_STORED], status_tally[STATUS_FULL],
             status_tally[STATUS_FOUND], status_tally[STATUS_NONE]);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d failures", error_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // request driver with bursts and gaps
  always @(posedge clk) begin : driver
    request_t head;
    bit       taken;
    int       gap_left;
    int       burst_left;
    if (rst) begin
      req_bus.valid <= 1'b0;
      req_bus.func <= FUNC_WRITE;
      req_bus.match_key <= '0;
      req_bus.in_tx_id <= '0;
      req_bus.in_wallet_sig <= '0;
      req_bus.in_server_sig <= '0;
      req_bus.in_payload <= '0;
      gap_left = 0;
      burst_left = 0;
    end else if (!(req_bus.valid && !req_bus.ready)) begin
      taken = req_bus.valid;
      if (taken) begin
        reply_q.push_back(serve_request(request_q.pop_front()));
        items_taken <= items_taken + 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                   : $urandom_range(1, 30);
          gap_left = $urandom_range(0, 8);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        req_bus.valid <= 1'b0;
      end else if (request_q.size() == 0 ||
                   (request_q[0].hold && items_taken + int'(taken) != results_seen)) begin
        req_bus.valid <= 1'b0;
      end else begin
        head = request_q[0];
        req_bus.valid <= 1'b1;
        req_bus.func <= head.func;
        req_bus.match_key <= head.key;
        req_bus.in_tx_id <= head.rec.tx_id;
        req_bus.in_wallet_sig <= head.rec.wallet_sig;
        req_bus.in_server_sig <= head.rec.server_sig;
        req_bus.in_payload <= head.rec.payload;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : monitor
    reply_t      want;
    ready_mode_t ready_mode;
    int          mode_left;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      ready_mode = READY_ALWAYS;
      mode_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen <= results_seen + 1;
        if (reply_q.size() == 0) begin
          log_failure($sformatf("result %0d with no request pending, status %0d",
                                results_seen, rsp_bus.status));
        end else begin
          want = reply_q.pop_front();
          status_tally[want.status]++;
          compare_field("status", 64'(want.status), 64'(rsp_bus.status));
          compare_field("out_tx_id", 64'(want.rec.tx_id), 64'(rsp_bus.out_tx_id));
          compare_field("out_wallet_sig", 64'(want.rec.wallet_sig),
                        64'(rsp_bus.out_wallet_sig));
          compare_field("out_server_sig", 64'(want.rec.server_sig),
                        64'(rsp_bus.out_server_sig));
          compare_field("out_payload", 64'(want.rec.payload), 64'(rsp_bus.out_payload));
        end
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS: rsp_bus.ready <= 1'b1;
        READY_COIN: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
        READY_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_bus.ready <= (cycle_count % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
